[sv/assert_macros.svh]
// Assertion macros used by the top RTL file of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[sv/imufs_pkg.sv]
// Types and constants of the frame sync parser.
package imufs_pkg;

   localparam int unsigned FIELD_COUNT = 13;

   localparam logic [7:0] SYNC_FIRST_RST = 8'h75;
   localparam logic [7:0] SYNC_SECOND_RST = 8'h65;
   localparam logic [7:0] DESC_BYTE_RST = 8'h82;

   // configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_DESC_BYTE = 2'd2;

   // frame positions
   localparam logic [5:0] POS_FIRST_DATA = 6'd3;
   localparam logic [5:0] FRAME_END = 6'd58;
   localparam logic [5:0] POS_QUAT_LO = 6'd6;
   localparam logic [5:0] POS_QUAT_HI = 6'd21;
   localparam logic [5:0] POS_RATE_LO = 6'd26;
   localparam logic [5:0] POS_RATE_HI = 6'd37;
   localparam logic [5:0] POS_ACCEL_LO = 6'd42;
   localparam logic [5:0] POS_ACCEL_HI = 6'd53;
   localparam logic [5:0] POS_VALID_QUAT = 6'd23;
   localparam logic [5:0] POS_VALID_RATE = 6'd39;
   localparam logic [5:0] POS_VALID_ACCEL = 6'd55;

   // field store slots
   localparam logic [3:0] SLOT_QUAT = 4'd0;
   localparam logic [3:0] SLOT_RATE = 4'd4;
   localparam logic [3:0] SLOT_ACCEL = 4'd7;
   localparam logic [3:0] SLOT_VALID_QUAT = 4'd10;
   localparam logic [3:0] SLOT_VALID_RATE = 4'd11;
   localparam logic [3:0] SLOT_VALID_ACCEL = 4'd12;
   localparam logic [3:0] SLOT_LAST = 4'd12;

   typedef enum logic [1:0] {
      HUNT_IDLE,
      HUNT_SYNC2,
      HUNT_DESC,
      HUNT_DATA
   } hunt_state_type;

   typedef enum logic [1:0] {
      DRN_IDLE,
      DRN_READ,
      DRN_LOAD
   } drain_state_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] desc_byte;
   } sync_cfg_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  addr;
      logic [31:0] data;
   } store_wr_type;

endpackage

[sv/imufs_frame_sync_parser_unit.sv]
// Bytes are taken one per cycle while hunting or counting and no drain is under way.
// At the end of a frame the drain reads each field word from the field memory
// (registered read, then load of the result register); bytes are stalled for the
// whole drain, and longer if the result side stalls. Reset (synchronous, active
// high) clears hunt state, position and drain and sets the sync bytes to their
// defaults; the field memory is not cleared, every slot is written before it is read.
module imu_frame_sync_parser_unit (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // field results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_field_index,
   output logic [31:0] rsp_field_value,
   output logic        rsp_last_field,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import imufs_pkg::*;
`include "assert_macros.svh"

   logic [7:0] sync_first_ff;
   logic [7:0] sync_second_ff;
   logic [7:0] desc_byte_ff;

   sync_cfg_type cfg;
   store_wr_type wr;
   logic         accept;
   logic         frame_done;
   logic         busy;
   logic         csr_write;

   // register port always takes a word; unknown index is dropped
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         desc_byte_ff   <= DESC_BYTE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_data;
            CSR_SYNC_SECOND: sync_second_ff <= csr_data;
            CSR_DESC_BYTE:   desc_byte_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.sync_first  = sync_first_ff;
   assign cfg.sync_second = sync_second_ff;
   assign cfg.desc_byte   = desc_byte_ff;

   // no byte taken while the field memory is being drained
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   imufs_byte_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .cfg        (cfg),
      .wr         (wr),
      .frame_done (frame_done)
   );

   imufs_field_store u_store (
      .clock           (clock),
      .reset           (reset),
      .wr              (wr),
      .frame_done      (frame_done),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_last_field  (rsp_last_field)
   );

   // end of frame blocks input for the drain
   `ASSERT_NXT(a_stall_after_frame, clock, reset, frame_done, req_stall)
   // the last word of a frame carries the last slot
   `ASSERT_IMP(a_last_slot, clock, reset, rsp_valid && rsp_last_field, rsp_field_index == SLOT_LAST)
   // no memory write while the drain reads it
   `ASSERT_IMP(a_no_write_in_drain, clock, reset, busy, !wr.en)
   // a sync byte write lands in its register
   `ASSERT_NXT(a_csr_first, clock, reset, csr_write && csr_index == CSR_SYNC_FIRST, sync_first_ff == $past(csr_data))

endmodule

[sv/imufs_byte_parser.sv]
// Header hunt, frame byte counting and field word assembly.
module imufs_byte_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  imufs_pkg::sync_cfg_type cfg,
   output imufs_pkg::store_wr_type wr,
   output logic                   frame_done
);
   import imufs_pkg::*;

   hunt_state_type hunt_ff, hunt_in;
   logic [5:0]     pos_ff, pos_in;
   logic [31:0]    word_ff, word_in;

   logic [5:0]  pos_nxt;
   logic [5:0]  start;
   logic [5:0]  off;
   logic [3:0]  base;
   logic        in_word;
   logic [31:0] word_shift;

   assign pos_nxt    = pos_ff + 6'd1;
   assign word_shift = {word_ff[23:0], rx_byte};
   assign off        = pos_ff - start;

   // which float group the current position falls in
   always_comb begin
      in_word = 1'b1;
      start   = POS_QUAT_LO;
      base    = SLOT_QUAT;
      if (pos_ff >= POS_QUAT_LO && pos_ff <= POS_QUAT_HI) begin
         start = POS_QUAT_LO;
         base  = SLOT_QUAT;
      end else if (pos_ff >= POS_RATE_LO && pos_ff <= POS_RATE_HI) begin
         start = POS_RATE_LO;
         base  = SLOT_RATE;
      end else if (pos_ff >= POS_ACCEL_LO && pos_ff <= POS_ACCEL_HI) begin
         start = POS_ACCEL_LO;
         base  = SLOT_ACCEL;
      end else begin
         in_word = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff <= HUNT_IDLE;
         pos_ff  <= '0;
         word_ff <= '0;
      end else begin
         hunt_ff <= hunt_in;
         pos_ff  <= pos_in;
         word_ff <= word_in;
      end
   end

   always_comb begin
      hunt_in    = hunt_ff;
      pos_in     = pos_ff;
      word_in    = word_ff;
      wr         = '0;
      frame_done = 1'b0;
      if (accept) begin
         case (hunt_ff)
            HUNT_IDLE: begin
               if (rx_byte == cfg.sync_first) hunt_in = HUNT_SYNC2;
            end
            HUNT_SYNC2: begin
               if (rx_byte == cfg.sync_second) hunt_in = HUNT_DESC;
            end
            HUNT_DESC: begin
               if (rx_byte == cfg.desc_byte) begin
                  hunt_in = HUNT_DATA;
                  pos_in  = POS_FIRST_DATA;
               end
            end
            HUNT_DATA: begin
               pos_in = pos_nxt;
               if (pos_ff == POS_VALID_QUAT) begin
                  wr.en   = 1'b1;
                  wr.addr = SLOT_VALID_QUAT;
                  wr.data = {24'd0, rx_byte};
               end else if (pos_ff == POS_VALID_RATE) begin
                  wr.en   = 1'b1;
                  wr.addr = SLOT_VALID_RATE;
                  wr.data = {24'd0, rx_byte};
               end else if (pos_ff == POS_VALID_ACCEL) begin
                  wr.en   = 1'b1;
                  wr.addr = SLOT_VALID_ACCEL;
                  wr.data = {24'd0, rx_byte};
               end else if (in_word) begin
                  word_in = word_shift;
                  // big-endian: fourth byte completes the word
                  if (off[1:0] == 2'b11) begin
                     wr.en   = 1'b1;
                     wr.addr = base + off[5:2];
                     wr.data = word_shift;
                  end
               end
               if (pos_nxt == FRAME_END) begin
                  hunt_in    = HUNT_IDLE;
                  pos_in     = '0;
                  frame_done = 1'b1;
               end
            end
            default: hunt_in = HUNT_IDLE;
         endcase
      end
   end

endmodule

[sv/imufs_field_store.sv]
// Field memory and the end-of-frame drain to the result register.
module imufs_field_store (
   input  logic                   clock,
   input  logic                   reset,
   input  imufs_pkg::store_wr_type wr,
   input  logic                   frame_done,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_field_index,
   output logic [31:0]            rsp_field_value,
   output logic                   rsp_last_field
);
   import imufs_pkg::*;

   logic [31:0] mem [FIELD_COUNT];
   logic [31:0] rd_data_ff;

   drain_state_type state_ff, state_in;
   logic [3:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [3:0]      rsp_index_ff;
   logic [31:0]     rsp_value_ff;
   logic            rsp_last_ff;
   logic            rd_en;
   logic            load;

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      if (rd_en) rd_data_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DRN_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_index_ff <= idx_ff;
         rsp_value_ff <= rd_data_ff;
         rsp_last_ff  <= (idx_ff == SLOT_LAST);
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rd_en    = 1'b0;
      load     = 1'b0;
      case (state_ff)
         DRN_IDLE: begin
            if (frame_done) begin
               state_in = DRN_READ;
               idx_in   = '0;
            end
         end
         DRN_READ: begin
            rd_en    = 1'b1;
            state_in = DRN_LOAD;
         end
         DRN_LOAD: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               load = 1'b1;
               if (idx_ff == SLOT_LAST) begin
                  state_in = DRN_IDLE;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = DRN_READ;
               end
            end
         end
         default: state_in = DRN_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   assign busy            = (state_ff != DRN_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_index = rsp_index_ff;
   assign rsp_field_value = rsp_value_ff;
   assign rsp_last_field  = rsp_last_ff;

endmodule

[verif/tb_imu_frame_sync_parser_unit.sv]
// Testbench for imu_frame_sync_parser_unit: byte stimulus, frame predictor, field checker.
module tb_imu_frame_sync_parser_unit;
   import imufs_pkg::*;

   // Register index with no register behind it; a write there must be dropped.
   localparam logic [1:0] CSR_NONE = 2'd3;
   // Cycles allowed after the last field before the block is treated as idle.
   localparam int SETTLE_CYCLES = 40;
   // Watchdog: the run is ended as a failure when the cycle count reaches this limit.
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [3:0]  slot;
      logic [31:0] value;
      logic        last;
   } field_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_field_index;
   logic [31:0] rsp_field_value;
   logic        rsp_last_field;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SYNC_FIRST;
   logic [7:0]  csr_data = 8'h00;

   imu_frame_sync_parser_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_last_field  (rsp_last_field),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow of the parser: sync bytes, hunt state, frame position, the
   // word being assembled and the thirteen field slots.
   // ------------------------------------------------------------------
   sync_cfg_type   cfg = '{sync_first: SYNC_FIRST_RST, sync_second: SYNC_SECOND_RST,
                           desc_byte: DESC_BYTE_RST};
   hunt_state_type hunt = HUNT_IDLE;
   logic [5:0]     frame_pos = '0;
   logic [31:0]    word_acc = '0;
   logic [31:0]    field_shadow [FIELD_COUNT];

   field_word_type pending_fields [$];
   int             error_count = 0;
   int             cycle_count = 0;

   // Frame body to send, indexed by frame position (3..57 used).
   logic [7:0]     frame_body [64];

   // Idling knobs: percent chance of a gap after each sent byte / of a stall burst.
   bit             idle_on = 1'b1;
   int             gap_pct = 20;
   int             stall_pct = 20;

   // Long receiver hold, run by its own process.
   event           hold_start;
   int             hold_len = 0;
   logic           holding = 1'b0;
   int             stall_burst = 0;

   // Frame data byte at position pos. Validity bytes go straight to their
   // slots; word bytes shift in MSB first and land on every fourth byte.
   function automatic void take_frame_byte(input logic [5:0] pos, input logic [7:0] b);
      logic       in_word;
      logic [5:0] start;
      logic [3:0] base;
      logic [5:0] off;
      in_word = 1'b0;
      start = '0;
      base = '0;
      if (pos == POS_VALID_QUAT) begin
         field_shadow[SLOT_VALID_QUAT] = {24'd0, b};
      end else if (pos == POS_VALID_RATE) begin
         field_shadow[SLOT_VALID_RATE] = {24'd0, b};
      end else if (pos == POS_VALID_ACCEL) begin
         field_shadow[SLOT_VALID_ACCEL] = {24'd0, b};
      end else begin
         if (pos >= POS_QUAT_LO && pos <= POS_QUAT_HI) begin
            in_word = 1'b1; start = POS_QUAT_LO; base = SLOT_QUAT;
         end else if (pos >= POS_RATE_LO && pos <= POS_RATE_HI) begin
            in_word = 1'b1; start = POS_RATE_LO; base = SLOT_RATE;
         end else if (pos >= POS_ACCEL_LO && pos <= POS_ACCEL_HI) begin
            in_word = 1'b1; start = POS_ACCEL_LO; base = SLOT_ACCEL;
         end
         if (in_word) begin
            word_acc = {word_acc[23:0], b};
            off = pos - start;
            if (off[1:0] == 2'b11)
               field_shadow[base + off[5:2]] = word_acc;
         end
      end
   endfunction

   // One accepted byte. Mismatches while hunting are dropped without
   // restarting the hunt; once in the frame every byte is data.
   function automatic void parse_byte(input logic [7:0] b);
      field_word_type w;
      if (hunt == HUNT_IDLE && b == cfg.sync_first) begin
         hunt = HUNT_SYNC2;
      end else if (hunt == HUNT_SYNC2 && b == cfg.sync_second) begin
         hunt = HUNT_DESC;
      end else if (hunt == HUNT_DESC && b == cfg.desc_byte) begin
         hunt = HUNT_DATA;
         frame_pos = POS_FIRST_DATA;
      end else if (hunt == HUNT_DATA) begin
         take_frame_byte(frame_pos, b);
         frame_pos = frame_pos + 6'd1;
      end
      if (frame_pos == FRAME_END) begin
         frame_pos = '0;
         hunt = HUNT_IDLE;
         for (int k = 0; k < FIELD_COUNT; k++) begin
            w.slot  = 4'(k);
            w.value = field_shadow[k];
            w.last  = (4'(k) == SLOT_LAST);
            pending_fields.push_back(w);
         end
      end
   endfunction

   // Header byte the hunt waits for next.
   function automatic logic [7:0] header_byte();
      case (hunt)
         HUNT_IDLE:  return cfg.sync_first;
         HUNT_SYNC2: return cfg.sync_second;
         default:    return cfg.desc_byte;
      endcase
   endfunction

   task automatic flag_error(input string what);
      $display("mismatch @%0d: %s", cycle_count, what);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Byte sender. Prediction happens at the accepting edge, so the shadow
   // is current when the task returns. Valid stays high into the next
   // byte unless a gap is drawn.
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value);
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(value);
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic release_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending, wait for every predicted field, then let the block settle.
   task automatic wait_until_drained();
      release_input();
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called while no drain is under way.
   task automatic write_sync_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SYNC_FIRST:  cfg.sync_first = val;
         CSR_SYNC_SECOND: cfg.sync_second = val;
         CSR_DESC_BYTE:   cfg.desc_byte = val;
         default: ;  // no register, write dropped
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_sync(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
      write_sync_reg(CSR_SYNC_FIRST, a);
      write_sync_reg(CSR_SYNC_SECOND, b);
      write_sync_reg(CSR_DESC_BYTE, c);
   endtask

   // Feed whatever header bytes the hunt still needs.
   task automatic send_header();
      while (hunt != HUNT_DATA) begin
         case (hunt)
            HUNT_IDLE:  send_byte(cfg.sync_first);
            HUNT_SYNC2: send_byte(cfg.sync_second);
            default:    send_byte(cfg.desc_byte);
         endcase
      end
   endtask

   // Finish a frame from wherever the parser stands, body from frame_body.
   task automatic send_frame();
      send_header();
      while (hunt == HUNT_DATA) send_byte(frame_body[frame_pos]);
   endtask

   // Random body; words are biased toward all-zero, all-one and header-like.
   task automatic fill_random_body();
      int s;
      for (int p = 0; p < 64; p++)
         frame_body[p] = 8'($urandom_range(0, 255));
      for (int w = 0; w < 10; w++) begin
         s = (w < 4) ? POS_QUAT_LO + 4 * w :
             (w < 7) ? POS_RATE_LO + 4 * (w - 4) : POS_ACCEL_LO + 4 * (w - 7);
         case ($urandom_range(0, 5))
            0: for (int i = 0; i < 4; i++) frame_body[s + i] = 8'h00;
            1: for (int i = 0; i < 4; i++) frame_body[s + i] = 8'hFF;
            2: begin
               frame_body[s]     = cfg.sync_first;
               frame_body[s + 1] = cfg.sync_second;
               frame_body[s + 2] = cfg.desc_byte;
               frame_body[s + 3] = cfg.sync_first;
            end
            default: ;
         endcase
      end
      if ($urandom_range(0, 2) == 0) frame_body[POS_VALID_QUAT] = 8'h00;
      if ($urandom_range(0, 2) == 0) frame_body[POS_VALID_RATE] = 8'hFF;
      if ($urandom_range(0, 2) == 0) frame_body[POS_VALID_ACCEL] = 8'h00;
   endtask

   // ------------------------------------------------------------------
   // Result side: stall driver, long hold, checker, watchdog.
   // ------------------------------------------------------------------
   always begin
      @(hold_start);
      holding <= 1'b1;
      repeat (hold_len) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      if (holding) begin
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         rsp_stall   <= 1'b1;
         stall_burst <= stall_burst - 1;
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall   <= 1'b1;
         stall_burst <= $urandom_range(0, 13);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   field_word_type want;

   // Each accepted field word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fields.size() == 0) begin
            flag_error($sformatf("unexpected field slot %0d value %08h",
                                 rsp_field_index, rsp_field_value));
         end else begin
            want = pending_fields.pop_front();
            if (rsp_field_index !== want.slot)
               flag_error($sformatf("field_index %0d, want %0d", rsp_field_index, want.slot));
            if (rsp_field_value !== want.value)
               flag_error($sformatf("slot %0d field_value %08h, want %08h",
                                    want.slot, rsp_field_value, want.value));
            if (rsp_last_field !== want.last)
               flag_error($sformatf("slot %0d last_field %b, want %b",
                                    want.slot, rsp_last_field, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout: %0d field words outstanding", pending_fields.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hunt behavior at reset sync bytes: idle noise, mismatches that must
   // not restart the hunt, then a frame whose data is full of header bytes.
   task automatic test_hunt_and_header_data();
      gap_pct = 30; stall_pct = 30;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cfg.sync_second);      // ignored while idle
      send_byte(cfg.desc_byte);
      send_byte(cfg.sync_first);       // -> waiting for second
      send_byte(cfg.sync_first);       // ignored, no restart
      send_byte(cfg.desc_byte);
      send_byte(8'hFF);
      send_byte(cfg.sync_second);      // -> waiting for descriptor
      send_byte(cfg.sync_first);
      send_byte(cfg.sync_second);
      send_byte(8'h00);
      send_byte(cfg.desc_byte);        // frame starts
      // data that looks like headers, with extreme words
      for (int p = 0; p < 64; p++)
         frame_body[p] = (p % 3 == 0) ? cfg.sync_first :
                         (p % 3 == 1) ? cfg.sync_second : cfg.desc_byte;
      for (int i = 0; i < 4; i++) begin
         frame_body[POS_QUAT_LO + i]      = 8'h00;
         frame_body[POS_QUAT_LO + 4 + i]  = 8'hFF;
         frame_body[POS_RATE_LO + i]      = 8'hFF;
         frame_body[POS_ACCEL_LO + 8 + i] = 8'h00;
      end
      frame_body[POS_QUAT_LO + 12] = 8'h80;
      frame_body[POS_QUAT_LO + 15] = 8'h01;
      frame_body[POS_VALID_QUAT]   = 8'h00;
      frame_body[POS_VALID_RATE]   = 8'hFF;
      frame_body[POS_VALID_ACCEL]  = 8'h01;
      send_frame();
      wait_until_drained();
   endtask

   // Register writes in the middle of a frame and in the middle of a hunt.
   task automatic test_register_writes();
      gap_pct = 10; stall_pct = 10;
      fill_random_body();
      send_header();
      repeat (10) send_byte(frame_body[frame_pos]);
      wait_until_drained();
      // the next data byte now equals sync_first; still data
      write_sync_reg(CSR_SYNC_FIRST, frame_body[frame_pos]);
      send_frame();
      wait_until_drained();
      send_byte(cfg.sync_first);
      wait_until_drained();
      write_sync_reg(CSR_SYNC_SECOND, 8'h00);
      write_sync_reg(CSR_NONE, 8'hFF);   // dropped
   endtask

   // Extreme sync settings, including all three bytes equal, written while the
   // hunt or a frame is under way: in the hunt a near miss holds, the exact byte advances.
   task automatic test_sync_extremes();
      logic [7:0] sets [3][3];
      gap_pct = 50; stall_pct = 50;
      sets = '{'{8'hAA, 8'hAA, 8'hAA}, '{8'h00, 8'hFF, 8'h00}, '{8'hFF, 8'h00, 8'hFF}};
      for (int s = 0; s < 3; s++) begin
         write_all_sync(sets[s][0], sets[s][1], sets[s][2]);
         send_byte(header_byte() ^ 8'h01);
         send_byte(header_byte());
         release_input();
      end
      wait_until_drained();
   endtask

   // Closing stretch with no idling: the receiver holds off long while the
   // frame completes and more bytes keep coming, so the drain backs up and
   // the block must stall its byte input.
   task automatic test_backpressure();
      idle_on = 1'b0;
      gap_pct = 0; stall_pct = 0;
      write_all_sync(SYNC_FIRST_RST, SYNC_SECOND_RST, DESC_BYTE_RST);
      fill_random_body();
      hold_len = 400;
      -> hold_start;
      send_frame();
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      wait_until_drained();
   endtask

   initial begin
      for (int k = 0; k < FIELD_COUNT; k++)
         field_shadow[k] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_hunt_and_header_data();
      test_register_writes();
      test_sync_extremes();
      test_backpressure();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/imufs_pkg.sv
sv/imufs_byte_parser.sv
sv/imufs_field_store.sv
sv/imufs_frame_sync_parser_unit.sv
verif/tb_imu_frame_sync_parser_unit.sv
